// ===== design/bounded_array_table_assert.svh =====
// assertion macros used by the bounded array table checker
`ifndef BOUNDED_ARRAY_TABLE_ASSERT_SVH
`define BOUNDED_ARRAY_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BAT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BAT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bat_pkg.sv =====
// shared constants and types of the bounded array table
`default_nettype none

package bat_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int DATA_W   = 32;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_APPEND = 3'd0;
    localparam cmd_t CMD_POP    = 3'd1;
    localparam cmd_t CMD_READ   = 3'd2;
    localparam cmd_t CMD_WRITE  = 3'd3;
    localparam cmd_t CMD_REMOVE = 3'd4;
    localparam cmd_t CMD_SEARCH = 3'd5;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BOUNDS = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    // memory access issued by the sequencer in one cycle
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } bat_mem_req_t;

endpackage

`default_nettype wire

// ===== design/bounded_array_table.sv =====
// A request is taken in idle and executed; append, pop, write and errors then go straight to
// the response state, read waits for the ram data, and search and remove walk the entries.
// Search and remove walk the entry ram at one entry per cycle through its single read
// port; one request is in work at a time.
// A new request is taken while the previous response waits in the output register.
// Reset (rst_n, async, active low) empties the table; entry ram contents are not cleared.
`default_nettype none

module bounded_array_table
    import bat_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               cmd,
    input  wire logic [IDX_W-1:0]         index,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      read_data,
    output logic                          found,
    output logic [1:0]                    status,
    output logic [CNT_W-1:0]              count
);

    bat_mem_req_t      mem_req;
    logic [DATA_W-1:0] mem_rdata;

    // sequencer
    bat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .found     (found),
        .status    (status),
        .count     (count),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // entry storage
    bat_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== design/bat_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
`default_nettype none

module bat_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/bat_ctrl.sv =====
// command sequencer: decodes a request, walks the entry memory, builds the response
`default_nettype none

module bat_ctrl
    import bat_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               cmd,
    input  wire logic [IDX_W-1:0]         index,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      read_data,
    output logic                          found,
    output logic [1:0]                    status,
    output logic [CNT_W-1:0]              count,
    output bat_mem_req_t                  mem_req,
    input  wire logic [DATA_W-1:0]        mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RWAIT,
        S_SRCH,
        S_REMV,
        S_RESP
    } state_t;

    state_t            state_reg,      state_next;
    cmd_t              cmd_reg,        cmd_next;
    logic [IDX_W-1:0]  idx_reg,        idx_next;
    logic [DATA_W-1:0] val_reg,        val_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic [CNT_W-1:0]  ptr_reg,        ptr_next;
    logic [IDX_W-1:0]  wr_ptr_reg,     wr_ptr_next;
    logic              pend_reg,       pend_next;
    logic [DATA_W-1:0] res_data_reg,   res_data_next;
    logic              res_found_reg,  res_found_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0] out_data_reg,   out_data_next;
    logic              out_found_reg,  out_found_next;
    status_t           out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_count_reg,  out_count_next;

    logic in_range;
    logic is_full;

    assign in_range = ({1'b0, idx_reg} < count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));

    // next-state and memory access logic
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pend_next       = pend_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_req         = '0;

        // response taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    idx_next   = index;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_data_next   = '0;
                res_found_next  = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_RESP;
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = count_reg[IDX_W-1:0];
                            mem_req.wdata = val_reg;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    CMD_READ:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ST_BOUNDS;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = idx_reg;
                            state_next    = S_RWAIT;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ST_BOUNDS;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = idx_reg;
                            mem_req.wdata = val_reg;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = ST_BOUNDS;
                        end
                        else
                        begin
                            ptr_next    = {1'b0, idx_reg} + CNT_W'(1);
                            wr_ptr_next = idx_reg;
                            pend_next   = 1'b0;
                            state_next  = S_REMV;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ptr_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SRCH;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // read data returns in the cycle after the address is issued
            S_RWAIT:
            begin
                res_data_next = mem_rdata;
                state_next    = S_RESP;
            end

            // one read issued and one compare done per cycle
            S_SRCH:
            begin
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    res_found_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_RESP;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                end
            end

            // read entry i+1 and write it back to i in the following cycle
            S_REMV:
            begin
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wr_ptr_reg;
                    mem_req.wdata = mem_rdata;
                    wr_ptr_next   = wr_ptr_reg + IDX_W'(1);
                end
                if (ptr_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            // hand the result to the output register once it is free
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_APPEND;
            idx_reg        <= '0;
            val_reg        <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            wr_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            res_data_reg   <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_found_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            idx_reg        <= idx_next;
            val_reg        <= val_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            pend_reg       <= pend_next;
            res_data_reg   <= res_data_next;
            res_found_reg  <= res_found_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_found_reg  <= out_found_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign found     = out_found_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

`default_nettype wire

// ===== design/bat_checker.sv =====
// port-level checks of the bounded array table and their binding
`default_nettype none

`include "bounded_array_table_assert.svh"

module bat_checker
    import bat_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic [2:0]               cmd,
    input wire logic [IDX_W-1:0]         index,
    input wire logic signed [DATA_W-1:0] value,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DATA_W-1:0] read_data,
    input wire logic                     found,
    input wire logic [1:0]               status,
    input wire logic [CNT_W-1:0]         count
);

    // a stalled response holds
    `BAT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(count), "stalled response changed")

    // busy in the cycle after a request is taken
    `BAT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken back to back")

    // found flag only comes with ok status and zero read data
    `BAT_ASSERT_IMP(a_found_clean, out_valid && found, status == ST_OK && read_data == '0, "found with bad status or data")

    // full error only when the table is at capacity
    `BAT_ASSERT_IMP(a_full_count, out_valid && status == ST_FULL, count == CNT_W'(CAPACITY), "full error below capacity")

    // count stays within capacity
    `BAT_ASSERT_IMP(a_count_range, out_valid, count <= CNT_W'(CAPACITY), "count beyond capacity")

endmodule

bind bounded_array_table bat_checker u_bat_checker (.*);

`default_nettype wire

// ===== sim/tb_bounded_array_table.sv =====
// testbench for the bounded array table: directed, backpressure and random requests

module tb_bounded_array_table;
    import bat_pkg::*;

    localparam cmd_t    CMD_SPARE_6  = 3'd6;
    localparam cmd_t    CMD_SPARE_7  = 3'd7;
    localparam int      LONG_HOLD    = 300;
    localparam int      RANDOM_ITEMS = 540;
    localparam longint  LIMIT_CYCLES = 4000000;

    // one response of the table as the checker sees it
    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     found;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } table_reply_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    cmd_t                     cmd;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] read_data;
    logic                     found;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;

    // shadow copy of the table contents
    logic [DATA_W-1:0]        shadow_entries [CAPACITY];
    int                       shadow_count;
    table_reply_t             pending_replies [$];

    int                       error_count;
    int                       replies_checked;
    int                       cmd_seen [8];
    int                       bounds_errors;
    int                       full_errors;
    int                       search_hits;
    int                       peak_fill;
    int                       long_holds;
    bit                       no_idle;
    bit                       long_hold_req;

    bounded_array_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .found     (found),
        .status    (status),
        .count     (count)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // apply one request to the shadow table and work out its response
    function automatic table_reply_t table_apply(input cmd_t c, input logic [IDX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] val);
        table_reply_t r;
        int i;
        r = '0;
        r.status = ST_OK;
        cmd_seen[c]++;
        case (c)
            CMD_APPEND:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                    full_errors++;
                end
                else
                begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            CMD_POP:
            begin
                if (shadow_count > 0)
                    shadow_count--;
            end
            CMD_READ:
            begin
                if (idx >= shadow_count)
                    r.status = ST_BOUNDS;
                else
                    r.read_data = shadow_entries[idx];
            end
            CMD_WRITE:
            begin
                if (idx >= shadow_count)
                    r.status = ST_BOUNDS;
                else
                    shadow_entries[idx] = val;
            end
            CMD_REMOVE:
            begin
                if (idx >= shadow_count)
                    r.status = ST_BOUNDS;
                else
                begin
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end
            end
            CMD_SEARCH:
            begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_entries[i] == val)
                        r.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (r.status == ST_BOUNDS)
            bounds_errors++;
        if (r.found)
            search_hits++;
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // offer one request after a random gap and record its expected response
    task automatic send_request(input cmd_t c, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        index    <= idx;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        pending_replies.push_back(table_apply(c, idx, val));
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                note_failure($sformatf("response with none expected: data %h found %b st %0d cnt %0d",
                                       read_data, found, status, count));
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (read_data !== want.read_data || found !== want.found ||
                    status !== want.status || count !== want.count)
                    note_failure($sformatf(
                        "expected data %h found %b st %0d cnt %0d, got %h %b %0d %0d",
                        want.read_data, want.found, want.status, want.count,
                        read_data, found, status, count));
            end
        end
    end

    // receiver side: random stalls plus a long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_holds++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            n = pick_gap();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // empty table errors, field extremes, every command and the unused codes
    task automatic test_directed();
        send_request(CMD_POP,    '0,       32'h0);
        send_request(CMD_READ,   '0,       32'h0);
        send_request(CMD_WRITE,  '0,       32'h1234_5678);
        send_request(CMD_REMOVE, '0,       32'h0);
        send_request(CMD_SEARCH, '0,       32'h0);
        send_request(CMD_APPEND, '0,       32'h8000_0000);
        send_request(CMD_APPEND, '1,       32'h7fff_ffff);
        send_request(CMD_APPEND, '0,       32'h0);
        send_request(CMD_APPEND, '0,       32'hffff_ffff);
        send_request(CMD_READ,   10'd0,    32'h0);
        send_request(CMD_READ,   10'd3,    32'h0);
        send_request(CMD_READ,   10'd4,    32'h0);
        send_request(CMD_READ,   '1,       32'hffff_ffff);
        send_request(CMD_WRITE,  10'd1,    32'h5555_5555);
        send_request(CMD_WRITE,  10'd4,    32'haaaa_aaaa);
        send_request(CMD_SEARCH, '1,       32'h5555_5555);
        send_request(CMD_SEARCH, '0,       32'h7fff_ffff);
        send_request(CMD_SEARCH, '0,       32'hffff_ffff);
        send_request(CMD_REMOVE, 10'd1,    32'h0);
        send_request(CMD_REMOVE, 10'd2,    32'h0);
        send_request(CMD_READ,   10'd1,    32'h0);
        send_request(CMD_SPARE_6, '1,      32'hffff_ffff);
        send_request(CMD_SPARE_7, 10'd2,   32'h8000_0000);
        send_request(CMD_POP,    '0,       32'h0);
        send_request(CMD_REMOVE, '1,       32'h0);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_hold_off();
        int k;
        no_idle = 1'b1;
        long_hold_req = 1'b1;
        for (k = 0; k < 16; k++)
            send_request((k % 2) ? CMD_READ : CMD_APPEND, '0, $urandom);
        no_idle = 1'b0;
    endtask

    // random mix of commands, indexes near the fill level and values that hit
    task automatic test_random_mix(input int n_items);
        int k, r, s, v, app;
        cmd_t c;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] val;
        for (k = 0; k < n_items; k++)
        begin
            no_idle = ((k / 60) % 4 == 3);
            app = (shadow_count < 192) ? 30 : 8;
            r = $urandom_range(0, app + 77);
            if (r < app)
                c = CMD_APPEND;
            else if (r < app + 14)
                c = CMD_POP;
            else if (r < app + 36)
                c = CMD_READ;
            else if (r < app + 50)
                c = CMD_WRITE;
            else if (r < app + 61)
                c = CMD_REMOVE;
            else if (r < app + 74)
                c = CMD_SEARCH;
            else
                c = (r % 2) ? CMD_SPARE_7 : CMD_SPARE_6;

            s = $urandom_range(0, 19);
            if (shadow_count > 0 && s < 15)
                idx = IDX_W'($urandom_range(0, shadow_count - 1));
            else if (s < 17)
                idx = shadow_count[IDX_W-1:0];
            else
                idx = IDX_W'($urandom);

            v = $urandom_range(0, 19);
            if (v < 11)
                val = $urandom;
            else if (v < 14)
                val = $urandom_range(0, 7) - 4;
            else if (v < 16)
                case ($urandom_range(0, 3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7fff_ffff;
                    2: val = 32'h0;
                    default: val = 32'hffff_ffff;
                endcase
            else if (shadow_count > 0)
                val = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else
                val = $urandom;

            send_request(c, idx, val);
        end
        no_idle = 1'b0;
    endtask

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("TB_ERROR");
        $finish;
    end

    // reset, test sequence and final verdict
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_APPEND;
        index    = '0;
        value    = '0;
        shadow_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_hold_off();
        test_random_mix(RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 10) @(posedge clk);

        $display("covered %0d responses: %0d append (%0d full), %0d pop, %0d read, %0d write,",
                 replies_checked, cmd_seen[CMD_APPEND], full_errors, cmd_seen[CMD_POP],
                 cmd_seen[CMD_READ], cmd_seen[CMD_WRITE]);
        $display("%0d remove, %0d search (%0d hits), %0d unused, %0d bounds, peak %0d, holds %0d",
                 cmd_seen[CMD_REMOVE], cmd_seen[CMD_SEARCH], search_hits,
                 cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7], bounds_errors, peak_fill,
                 long_holds);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
